// ----- rtl/core/ultrasonic_ranging_obstacle_detector_defines.svh -----
// assertion macros for the ultrasonic ranging obstacle detector
// used by the top level only, empty bodies under synthesis
`ifndef ULTRASONIC_RANGING_OBSTACLE_DETECTOR_DEFINES_SVH
`define ULTRASONIC_RANGING_OBSTACLE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define URD_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define URD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define URD_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define URD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// ----- rtl/core/urod_pkg.sv -----
// types and constants of the ultrasonic ranging obstacle detector
// no dependencies
`default_nettype none

package urod_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_TIME_ECHO = 3'd4
  } urod_phase_t;

  // configuration register indexes
  localparam logic [2:0] CFG_THRESHOLD_CM  = 3'd0;
  localparam logic [2:0] CFG_HITS_NEEDED   = 3'd1;
  localparam logic [2:0] CFG_MISSES_NEEDED = 3'd2;
  localparam logic [2:0] CFG_DOWNSAMPLE    = 3'd3;
  localparam logic [2:0] CFG_ECHO_TIMEOUT  = 3'd4;
  localparam logic [2:0] CFG_TRIGGER_WIDTH = 3'd5;
  localparam logic [2:0] CFG_CYCLES_PER_CM = 3'd6;

  // register values after reset
  localparam logic [15:0] RST_THRESHOLD_CM  = 16'd20;
  localparam logic [3:0]  RST_HITS_NEEDED   = 4'd3;
  localparam logic [3:0]  RST_MISSES_NEEDED = 4'd3;
  localparam logic [7:0]  RST_DOWNSAMPLE    = 8'd10;
  localparam logic [15:0] RST_ECHO_TIMEOUT  = 16'd30000;
  localparam logic [7:0]  RST_TRIGGER_WIDTH = 8'd10;
  localparam logic [7:0]  RST_CYCLES_PER_CM = 8'd58;

  localparam logic [15:0] TRIG_LOW_TICKS = 16'd2;
  localparam logic [15:0] DIST_MAX       = 16'hFFFF;

  typedef struct packed {
    logic echo_level;
    logic task_strobe;
    logic motor_moving;
    logic at_end_position;
  } urod_in_t;

  typedef struct packed {
    logic        trigger_level;
    logic        close_request;
    logic        reading_valid;
    logic        reading_timed_out;
    logic [15:0] distance_cm;
    logic        busy_res;
  } urod_out_t;

  typedef struct packed {
    logic [15:0] threshold_cm;
    logic [3:0]  hits_needed;
    logic [3:0]  misses_needed;
    logic [7:0]  downsample_period;
    logic [15:0] echo_timeout;
    logic [7:0]  trigger_width;
    logic [7:0]  cycles_per_cm;
  } urod_cfg_t;

  typedef struct packed {
    urod_phase_t phase;
    logic [15:0] phase_ticks;
    logic [7:0]  cm_subcount;
    logic [15:0] distance_count;
    logic [7:0]  strobe_count;
    logic [3:0]  hit_count;
    logic [3:0]  miss_count;
    logic        close_armed_off;
  } urod_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/urod_step.sv -----
// next-state and result logic for one tick of the ranging sequence
// depends on urod_pkg
`default_nettype none

module urod_step
  import urod_pkg::*;
(
  input  wire urod_cfg_t   cfg,
  input  wire urod_state_t cur,
  input  wire urod_in_t    item,
  output urod_state_t nxt,
  output urod_out_t   res
);

  logic [15:0] limit;
  logic [7:0]  tw1;
  logic [7:0]  cpcm1;
  logic [7:0]  ds1;
  logic [3:0]  hn1;
  logic [3:0]  mn1;

  logic [15:0] tk_base, tk_inc, wr_ticks;
  logic [7:0]  cm_base, cm_inc, cm_echo;
  logic [15:0] dist_base, dist_echo;
  logic        cm_roll;

  logic        fin, tmo, trig, start, hit, close_req;
  logic [15:0] dist_cm;
  urod_phase_t phase_nxt;
  urod_state_t upd;

  // zero registers act as one
  assign limit = (cfg.echo_timeout == 16'd0) ? 16'd1 : cfg.echo_timeout;
  assign tw1   = (cfg.trigger_width == 8'd0) ? 8'd1 : cfg.trigger_width;
  assign cpcm1 = (cfg.cycles_per_cm == 8'd0) ? 8'd1 : cfg.cycles_per_cm;
  assign ds1   = (cfg.downsample_period == 8'd0) ? 8'd1 : cfg.downsample_period;
  assign hn1   = (cfg.hits_needed == 4'd0) ? 4'd1 : cfg.hits_needed;
  assign mn1   = (cfg.misses_needed == 4'd0) ? 4'd1 : cfg.misses_needed;

  // one echo-high tick; counters start from zero on the rising edge
  assign tk_base   = (cur.phase == PH_WAIT_RISE) ? 16'd0 : cur.phase_ticks;
  assign cm_base   = (cur.phase == PH_WAIT_RISE) ? 8'd0 : cur.cm_subcount;
  assign dist_base = (cur.phase == PH_WAIT_RISE) ? 16'd0 : cur.distance_count;
  assign tk_inc    = tk_base + 16'd1;
  assign cm_inc    = cm_base + 8'd1;
  assign cm_roll   = (cm_inc >= cpcm1);
  assign cm_echo   = cm_roll ? 8'd0 : cm_inc;
  assign dist_echo = (cm_roll && (dist_base != DIST_MAX)) ? dist_base + 16'd1 : dist_base;
  assign wr_ticks  = cur.phase_ticks + 16'd1;

  // datapath and counters
  always_comb begin
    upd   = cur;
    trig  = 1'b0;
    fin   = 1'b0;
    tmo   = 1'b0;
    start = 1'b0;
    case (cur.phase)
      PH_TRIG_LOW: begin
        if (cur.phase_ticks >= TRIG_LOW_TICKS) begin
          upd.phase_ticks = 16'd1;
          trig            = 1'b1;
        end else begin
          upd.phase_ticks = wr_ticks;
        end
      end
      PH_TRIG_HIGH: begin
        if (cur.phase_ticks >= {8'd0, tw1}) begin
          upd.phase_ticks = 16'd0;
        end else begin
          upd.phase_ticks = wr_ticks;
          trig            = 1'b1;
        end
      end
      PH_WAIT_RISE, PH_TIME_ECHO: begin
        if (item.echo_level) begin
          upd.phase_ticks    = tk_inc;
          upd.cm_subcount    = cm_echo;
          upd.distance_count = dist_echo;
          tmo                = (tk_inc >= limit);
          fin                = tmo;
        end else if (cur.phase == PH_WAIT_RISE) begin
          upd.phase_ticks = wr_ticks;
          tmo             = (wr_ticks >= limit);
          fin             = tmo;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        if (item.task_strobe) begin
          if (item.at_end_position) begin
            upd.close_armed_off = 1'b0;
          end else if (({1'b0, cur.strobe_count} + 9'd1) < {1'b0, ds1}) begin
            upd.strobe_count = cur.strobe_count + 8'd1;
          end else begin
            upd.strobe_count = 8'd0;
            if (item.motor_moving) begin
              upd.hit_count       = 4'd0;
              upd.miss_count      = 4'd0;
              upd.close_armed_off = 1'b0;
            end else begin
              start           = 1'b1;
              upd.phase_ticks = 16'd1;
            end
          end
        end
      end
    endcase

    dist_cm   = 16'd0;
    hit       = 1'b0;
    close_req = 1'b0;
    if (fin) begin
      dist_cm = tmo ? 16'd0 : upd.distance_count;
      hit     = !tmo && (dist_cm <= cfg.threshold_cm);
      if (hit) begin
        if (upd.hit_count < hn1) upd.hit_count = upd.hit_count + 4'd1;
        upd.miss_count = 4'd0;
      end else begin
        if (upd.miss_count < mn1) upd.miss_count = upd.miss_count + 4'd1;
        upd.hit_count = 4'd0;
      end
      if ((upd.hit_count >= hn1) && !upd.close_armed_off) begin
        close_req           = 1'b1;
        upd.close_armed_off = 1'b1;
      end
      if (upd.miss_count >= mn1) upd.close_armed_off = 1'b0;
      upd.phase_ticks = 16'd0;
    end
  end

  // phase sequencing
  always_comb begin
    case (cur.phase)
      PH_IDLE:      phase_nxt = start ? PH_TRIG_LOW : PH_IDLE;
      PH_TRIG_LOW:  phase_nxt = (cur.phase_ticks >= TRIG_LOW_TICKS) ? PH_TRIG_HIGH : PH_TRIG_LOW;
      PH_TRIG_HIGH: phase_nxt = (cur.phase_ticks >= {8'd0, tw1}) ? PH_WAIT_RISE : PH_TRIG_HIGH;
      PH_WAIT_RISE: begin
        if (fin)                  phase_nxt = PH_IDLE;
        else if (item.echo_level) phase_nxt = PH_TIME_ECHO;
        else                      phase_nxt = PH_WAIT_RISE;
      end
      PH_TIME_ECHO: phase_nxt = fin ? PH_IDLE : PH_TIME_ECHO;
      default:      phase_nxt = start ? PH_TRIG_LOW : PH_IDLE;
    endcase
  end

  // result fields
  always_comb begin
    nxt                   = upd;
    nxt.phase             = phase_nxt;
    res.trigger_level     = trig;
    res.close_request     = close_req;
    res.reading_valid     = fin;
    res.reading_timed_out = tmo;
    res.distance_cm       = dist_cm;
    res.busy_res          = (phase_nxt != PH_IDLE);
  end

endmodule

`default_nettype wire

// ----- rtl/core/ultrasonic_ranging_obstacle_detector.sv -----
// ultrasonic echo ranging and obstacle debounce, one item per microsecond tick
// a result item is offered once its input item has been accepted and has passed through
// the input register, then the result register; throughput one item per cycle while out_stall is low
// reset (rst_n low, synchronous): sequencer idle, all counters zero,
// registers at their defaults, both pipeline stages empty
// depends on urod_pkg, urod_step and the assertion macro header
`default_nettype none

`include "ultrasonic_ranging_obstacle_detector_defines.svh"

module ultrasonic_ranging_obstacle_detector
  import urod_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,

  // tick items in
  input  wire        in_valid,
  output logic       in_stall,
  input  wire urod_in_t in_data,

  // result items out
  output logic       out_valid,
  input  wire        out_stall,
  output urod_out_t  out_data,

  // register writes
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [2:0]  cfg_index,
  input  wire [15:0] cfg_data
);

  // input stage
  logic        s1_valid_r;
  urod_in_t    s1_item_r;

  // result stage
  logic        out_valid_r;
  urod_out_t   out_data_r;

  // sequencer state and registers
  urod_state_t state_r;
  urod_state_t state_nxt;
  urod_cfg_t   cfg_r;
  urod_out_t   res;

  logic        adv;
  logic        fire;

  // the result register frees up when empty or being taken this cycle
  assign adv      = !out_valid_r || !out_stall;
  // the item in the input stage is evaluated as it moves into the result register
  assign fire     = s1_valid_r && adv;
  // the input register takes a new item whenever its current one moves on
  assign in_stall = s1_valid_r && !adv;

  // register writes are always taken; the host writes only while no item is in flight, not enforced here
  assign cfg_ready = 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // all tick evaluation lives in the step logic
  urod_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (s1_item_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  // sequencer state advances once per evaluated tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase           <= PH_IDLE;
      state_r.phase_ticks     <= 16'd0;
      state_r.cm_subcount     <= 8'd0;
      state_r.distance_count  <= 16'd0;
      state_r.strobe_count    <= 8'd0;
      state_r.hit_count       <= 4'd0;
      state_r.miss_count      <= 4'd0;
      state_r.close_armed_off <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // register file; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_cm      <= RST_THRESHOLD_CM;
      cfg_r.hits_needed       <= RST_HITS_NEEDED;
      cfg_r.misses_needed     <= RST_MISSES_NEEDED;
      cfg_r.downsample_period <= RST_DOWNSAMPLE;
      cfg_r.echo_timeout      <= RST_ECHO_TIMEOUT;
      cfg_r.trigger_width     <= RST_TRIGGER_WIDTH;
      cfg_r.cycles_per_cm     <= RST_CYCLES_PER_CM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD_CM:  cfg_r.threshold_cm      <= cfg_data;
        CFG_HITS_NEEDED:   cfg_r.hits_needed       <= cfg_data[3:0];
        CFG_MISSES_NEEDED: cfg_r.misses_needed     <= cfg_data[3:0];
        CFG_DOWNSAMPLE:    cfg_r.downsample_period <= cfg_data[7:0];
        CFG_ECHO_TIMEOUT:  cfg_r.echo_timeout      <= cfg_data;
        CFG_TRIGGER_WIDTH: cfg_r.trigger_width     <= cfg_data[7:0];
        CFG_CYCLES_PER_CM: cfg_r.cycles_per_cm     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // a timed-out reading carries no distance and can never raise a close
  `URD_ASSERT_IMPL(a_tmo_clean, clk, rst_n, out_valid_r && out_data_r.reading_timed_out, out_data_r.reading_valid && (out_data_r.distance_cm == 16'd0) && !out_data_r.close_request, "timed-out reading with distance or close")

  // a finished reading always returns the sequencer to idle
  `URD_ASSERT_NEXT(a_idle_after_reading, clk, rst_n, fire && res.reading_valid, state_r.phase == PH_IDLE, "sequencer not idle after reading")

  // hit and miss streaks are mutually exclusive
  `URD_ASSERT_IMPL(a_streak_excl, clk, rst_n, state_r.hit_count != 4'd0, state_r.miss_count == 4'd0, "hit and miss counts both nonzero")

endmodule

`default_nettype wire

// ----- sim/tb_ultrasonic_ranging_obstacle_detector.sv -----
// testbench for the ultrasonic ranging obstacle detector: tick items in, result items out
// predicts every result item with its own sequencer copy and checks it field by field
// depends on urod_pkg and the ultrasonic_ranging_obstacle_detector top level
`timescale 1ns / 1ps

module tb_ultrasonic_ranging_obstacle_detector;
  import urod_pkg::*;

  localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;  // no register behind this index
  localparam int LONG_HOLD_CYCLES = 48;
  localparam int DRAIN_SETTLE = 4;  // a bit more than the two-stage latency
  localparam int RANDOM_ROUNDS = 6;
  localparam int ROUND_TICKS = 40;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  urod_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  urod_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // predictor copy of the registers and the sequencer state
  urod_cfg_t   ranger_cfg;
  urod_state_t ranger;

  urod_out_t   expected_results[$];
  int          mismatches = 0;
  int          ticks_sent = 0;
  bit          no_idle = 1'b0;        // last part of the run: both sides at full rate
  bit          long_hold_req = 1'b0;  // asks the receiver for one long hold-off

  ultrasonic_ranging_obstacle_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #(64'd5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // a zero in any count register behaves as one
  function automatic logic [15:0] or_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic void reset_ranger();
    ranger_cfg.threshold_cm      = RST_THRESHOLD_CM;
    ranger_cfg.hits_needed       = RST_HITS_NEEDED;
    ranger_cfg.misses_needed     = RST_MISSES_NEEDED;
    ranger_cfg.downsample_period = RST_DOWNSAMPLE;
    ranger_cfg.echo_timeout      = RST_ECHO_TIMEOUT;
    ranger_cfg.trigger_width     = RST_TRIGGER_WIDTH;
    ranger_cfg.cycles_per_cm     = RST_CYCLES_PER_CM;
    ranger = '0;
    ranger.phase = PH_IDLE;
  endfunction

  // one echo-high tick: width count plus whole-centimetre count, saturating
  function automatic void count_echo_tick();
    ranger.phase_ticks = ranger.phase_ticks + 16'd1;
    ranger.cm_subcount = ranger.cm_subcount + 8'd1;
    if (ranger.cm_subcount >= or_one(16'(ranger_cfg.cycles_per_cm))) begin
      ranger.cm_subcount = '0;
      if (ranger.distance_count < DIST_MAX) ranger.distance_count = ranger.distance_count + 16'd1;
    end
  endfunction

  function automatic urod_out_t range_tick(input urod_in_t it);
    urod_out_t   res;
    logic [15:0] limit;
    logic        finished;
    logic        hit;
    res = '0;
    finished = 1'b0;
    limit = or_one(ranger_cfg.echo_timeout);
    case (ranger.phase)
      PH_TRIG_LOW: begin
        if (ranger.phase_ticks >= TRIG_LOW_TICKS) begin
          ranger.phase = PH_TRIG_HIGH;
          ranger.phase_ticks = 16'd1;
          res.trigger_level = 1'b1;
        end else begin
          ranger.phase_ticks = ranger.phase_ticks + 16'd1;
        end
      end
      PH_TRIG_HIGH: begin
        if (ranger.phase_ticks >= or_one(16'(ranger_cfg.trigger_width))) begin
          ranger.phase = PH_WAIT_RISE;
          ranger.phase_ticks = '0;
        end else begin
          ranger.phase_ticks = ranger.phase_ticks + 16'd1;
          res.trigger_level = 1'b1;
        end
      end
      PH_WAIT_RISE: begin
        if (it.echo_level) begin
          // the rise tick is already the first echo tick
          ranger.phase = PH_TIME_ECHO;
          ranger.phase_ticks = '0;
          ranger.cm_subcount = '0;
          ranger.distance_count = '0;
          count_echo_tick();
        end else begin
          ranger.phase_ticks = ranger.phase_ticks + 16'd1;
        end
        if (ranger.phase_ticks >= limit) begin
          finished = 1'b1;
          res.reading_timed_out = 1'b1;
        end
      end
      PH_TIME_ECHO: begin
        if (!it.echo_level) begin
          finished = 1'b1;
        end else begin
          count_echo_tick();
          if (ranger.phase_ticks >= limit) begin
            finished = 1'b1;
            res.reading_timed_out = 1'b1;
          end
        end
      end
      default: begin
        ranger.phase = PH_IDLE;
        if (it.task_strobe) begin
          if (it.at_end_position) begin
            // end position rearms and the strobe is not counted
            ranger.close_armed_off = 1'b0;
          end else if (ranger.strobe_count + 16'd1 <
                       or_one(16'(ranger_cfg.downsample_period))) begin
            ranger.strobe_count = ranger.strobe_count + 8'd1;
          end else begin
            ranger.strobe_count = '0;
            if (it.motor_moving) begin
              ranger.hit_count = '0;
              ranger.miss_count = '0;
              ranger.close_armed_off = 1'b0;
            end else begin
              ranger.phase = PH_TRIG_LOW;
              ranger.phase_ticks = 16'd1;
            end
          end
        end
      end
    endcase

    if (finished) begin
      res.reading_valid = 1'b1;
      if (!res.reading_timed_out) res.distance_cm = ranger.distance_count;
      hit = !res.reading_timed_out && (res.distance_cm <= ranger_cfg.threshold_cm);
      if (hit) begin
        if (ranger.hit_count < or_one(16'(ranger_cfg.hits_needed)))
          ranger.hit_count = ranger.hit_count + 4'd1;
        ranger.miss_count = '0;
      end else begin
        if (ranger.miss_count < or_one(16'(ranger_cfg.misses_needed)))
          ranger.miss_count = ranger.miss_count + 4'd1;
        ranger.hit_count = '0;
      end
      // close request fires once per arming
      if (ranger.hit_count >= or_one(16'(ranger_cfg.hits_needed)) && !ranger.close_armed_off) begin
        res.close_request = 1'b1;
        ranger.close_armed_off = 1'b1;
      end
      if (ranger.miss_count >= or_one(16'(ranger_cfg.misses_needed)))
        ranger.close_armed_off = 1'b0;
      ranger.phase = PH_IDLE;
      ranger.phase_ticks = '0;
    end

    res.busy_res = (ranger.phase != PH_IDLE);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    urod_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("trigger_level", want.trigger_level, out_data.trigger_level);
        check_field("close_request", want.close_request, out_data.close_request);
        check_field("reading_valid", want.reading_valid, out_data.reading_valid);
        check_field("reading_timed_out", want.reading_timed_out, out_data.reading_timed_out);
        check_field("distance_cm", want.distance_cm, out_data.distance_cm);
        check_field("busy_res", want.busy_res, out_data.busy_res);
      end
    end
  end

  // receiver side: short random stall bursts, or one long hold-off on request
  initial begin : result_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 5);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one tick item, sometimes after a short gap, and predict it once accepted;
  // valid stays high afterwards, so anything that lets time pass lowers it first
  task automatic send_tick(input urod_in_t it);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(range_tick(it));
    ticks_sent++;
  endtask

  function automatic urod_in_t rand_tick();
    return urod_in_t'(4'($urandom));
  endfunction

  // sender pause until every predicted result item has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_THRESHOLD_CM:  ranger_cfg.threshold_cm      = val;
      CFG_HITS_NEEDED:   ranger_cfg.hits_needed       = val[3:0];
      CFG_MISSES_NEEDED: ranger_cfg.misses_needed     = val[3:0];
      CFG_DOWNSAMPLE:    ranger_cfg.downsample_period = val[7:0];
      CFG_ECHO_TIMEOUT:  ranger_cfg.echo_timeout      = val;
      CFG_TRIGGER_WIDTH: ranger_cfg.trigger_width     = val[7:0];
      CFG_CYCLES_PER_CM: ranger_cfg.cycles_per_cm     = val[7:0];
      default: ;
    endcase
  endtask

  // all seven registers, written only once the block has drained
  task automatic load_settings(input logic [15:0] thr, input logic [15:0] hits,
                               input logic [15:0] misses, input logic [15:0] ds,
                               input logic [15:0] tmo, input logic [15:0] tw,
                               input logic [15:0] cpc);
    wait_drain();
    write_reg(CFG_THRESHOLD_CM, thr);
    write_reg(CFG_HITS_NEEDED, hits);
    write_reg(CFG_MISSES_NEEDED, misses);
    write_reg(CFG_DOWNSAMPLE, ds);
    write_reg(CFG_ECHO_TIMEOUT, tmo);
    write_reg(CFG_TRIGGER_WIDTH, tw);
    write_reg(CFG_CYCLES_PER_CM, cpc);
  endtask

  // one ranging sequence: strobes until it starts, trigger ticks with random
  // content, rise_ticks low echo ticks, echo_ticks high ones, then the fall;
  // the predictor's phase steers it, so timeouts simply cut it short
  task automatic measure(input int rise_ticks, input int echo_ticks, input bit noisy);
    urod_in_t it;
    int n;
    while (ranger.phase == PH_IDLE) begin
      it = rand_tick();
      if (noisy) begin
        it.task_strobe     = ($urandom_range(0, 3) != 0);
        it.motor_moving    = ($urandom_range(0, 9) == 0);
        it.at_end_position = ($urandom_range(0, 9) == 0);
      end else begin
        it.task_strobe     = 1'b1;
        it.motor_moving    = 1'b0;
        it.at_end_position = 1'b0;
      end
      send_tick(it);
    end
    // strobes and motor bits are ignored while busy, so anything goes here
    while (ranger.phase == PH_TRIG_LOW || ranger.phase == PH_TRIG_HIGH)
      send_tick(rand_tick());
    for (n = 0; n < rise_ticks && ranger.phase == PH_WAIT_RISE; n++) begin
      it = rand_tick();
      it.echo_level = 1'b0;
      send_tick(it);
    end
    for (n = 0; n < echo_ticks && ranger.phase != PH_IDLE; n++) begin
      it = rand_tick();
      it.echo_level = 1'b1;
      send_tick(it);
    end
    while (ranger.phase != PH_IDLE) begin
      it = rand_tick();
      it.echo_level = 1'b0;
      send_tick(it);
    end
  endtask

  // random sequences sized to the current timeout, with some raw noise mixed in
  task automatic random_traffic(input int n_ticks);
    int stop_at;
    int lim;
    int rise;
    int width;
    stop_at = ticks_sent + n_ticks;
    lim = int'(or_one(ranger_cfg.echo_timeout));
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 8)) send_tick(rand_tick());
      end else begin
        rise  = $urandom_range(0, (lim + 2 < 35) ? lim + 2 : 35);
        width = $urandom_range(1, (lim + 2 < 40) ? lim + 2 : 40);
        measure(rise, width, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: ten strobes per measurement, short echo is a hit at 20 cm
  task automatic test_reset_defaults();
    measure(2, 5, 1'b0);
  endtask

  // smallest register values, threshold zero
  task automatic test_register_minimum();
    load_settings(16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    measure(2, 1, 1'b0);  // timeout on the first low echo tick
    measure(0, 1, 1'b0);  // rise tick already reaches the timeout
    load_settings(16'd0, 16'd1, 16'd1, 16'd1, 16'd8, 16'd1, 16'd2);
    measure(0, 1, 1'b0);  // zero cm, hit, close on first hit
    measure(0, 1, 1'b0);  // hit again, no second close
    measure(0, 4, 1'b0);  // two cm, miss rearms
    measure(0, 1, 1'b0);  // close again
  endtask

  // zero in every count register behaves as one
  task automatic test_register_zero();
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    measure(0, 1, 1'b0);
    measure(3, 1, 1'b0);
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd9, 16'd0, 16'd0);
    measure(1, 1, 1'b0);
    measure(1, 3, 1'b0);
  endtask

  // write to an index with no register leaves the settings alone
  task automatic test_unused_index();
    wait_drain();
    write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
    measure(1, 2, 1'b0);
  endtask

  // end position, motor moving, once-per-arming close, both timeouts
  task automatic test_special_cases();
    urod_in_t it;
    load_settings(16'd3, 16'd2, 16'd2, 16'd2, 16'd12, 16'd2, 16'd2);
    it = '0;
    it.task_strobe = 1'b1;
    it.at_end_position = 1'b1;
    send_tick(it);        // end position strobe, not counted
    it.at_end_position = 1'b0;
    send_tick(it);
    it.motor_moving = 1'b1;
    send_tick(it);        // due measurement skipped, counters cleared
    measure(1, 2, 1'b0);  // one cm, hit
    measure(1, 2, 1'b0);  // second hit, close
    measure(1, 2, 1'b0);  // still armed off
    measure(1, 10, 1'b0); // five cm, miss
    measure(14, 1, 1'b0); // echo never rises in time, miss, rearmed
    measure(0, 13, 1'b0); // echo stays high past the timeout
    measure(1, 2, 1'b0);
    measure(1, 2, 1'b0);  // close again
    it = '0;
    it.task_strobe = 1'b1;
    it.at_end_position = 1'b1;
    send_tick(it);        // end position rearms with hits still saturated
    measure(1, 2, 1'b0);  // close on the very next hit
    it.at_end_position = 1'b0;
    send_tick(it);
    it.motor_moving = 1'b1;
    send_tick(it);        // hit count cleared again
    measure(1, 2, 1'b0);
  endtask

  // largest register values, all data bits set
  task automatic test_register_maximum();
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    measure(3, 300, 1'b0);  // one cm at 255 ticks per cm
  endtask

  // receiver holds off long enough to back up the input, then a sender pause
  task automatic test_backpressure();
    load_settings(16'd4, 16'd2, 16'd2, 16'd1, 16'd16, 16'd3, 16'd2);
    long_hold_req = 1'b1;
    random_traffic(80);
    wait_drain();
    random_traffic(40);
  endtask

  task automatic test_random_settings();
    logic [15:0] thr;
    logic [3:0]  hits;
    logic [3:0]  misses;
    logic [7:0]  ds;
    logic [15:0] tmo;
    logic [7:0]  tw;
    logic [7:0]  cpc;
    thr    = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    hits   = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 3));
    misses = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 3));
    ds     = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 6)) : 8'($urandom_range(1, 3));
    tmo    = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(6, 30));
    tw     = 8'($urandom_range(0, 6));
    cpc    = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(1, 4));
    // upper data bits above the narrow registers are random and must be dropped
    load_settings(thr, {12'($urandom), hits}, {12'($urandom), misses}, {8'($urandom), ds},
                  tmo, {8'($urandom), tw}, {8'($urandom), cpc});
    random_traffic(ROUND_TICKS);
  endtask

  // closing stretch with no gaps and no stalls on either side
  task automatic test_steady_stream();
    wait_drain();
    no_idle = 1'b1;
    random_traffic(150);
  endtask

  initial begin : run
    int r;
    reset_ranger();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_minimum();
    test_register_zero();
    test_unused_index();
    test_special_cases();
    test_register_maximum();
    test_backpressure();
    for (r = 0; r < RANDOM_ROUNDS; r++) test_random_settings();
    test_steady_stream();

    wait_drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
